// File: src/bfk_pkg.sv
// ----------------------------------------------------------------------------
// bfk_pkg: shared definitions for the k-nearest-neighbor search block
// Default sizes, operation codes, the sequencer state type and the control
// bundle that the sequencer hands to the sorted best list.
// ----------------------------------------------------------------------------
package bfk_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int K_MAX_DEF      = 8;
  localparam int COORD_BITS_DEF = 18;

  localparam int OP_W  = 2;
  localparam int CFG_W = 4;
  localparam int TAG_W = 16;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_W-1:0] K_RESET = 4'd1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic             clear;
    logic [CFG_W-1:0] k_lim;
  } sort_ctl_t;

endpackage

// File: src/bfk_store.sv
// ----------------------------------------------------------------------------
// bfk_store: target point memory
// One write port for appends and one registered read port for the scan.
// ----------------------------------------------------------------------------
module bfk_store #(
  parameter int  MAX_POINTS = bfk_pkg::MAX_POINTS_DEF,
  parameter int  COORD_BITS = bfk_pkg::COORD_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_POINTS),
  localparam int PT_W       = 3 * COORD_BITS
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [PT_W-1:0]  wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [PT_W-1:0]  rd_data
);

  logic [PT_W-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/bfk_dist.sv
// ----------------------------------------------------------------------------
// bfk_dist: squared distance unit
// Pipelined difference, square and sum stages, fed one stored point per
// cycle from the memory read port and reused for every point of a query.
// ----------------------------------------------------------------------------
module bfk_dist #(
  parameter int  MAX_POINTS = bfk_pkg::MAX_POINTS_DEF,
  parameter int  COORD_BITS = bfk_pkg::COORD_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_POINTS),
  localparam int PT_W       = 3 * COORD_BITS,
  localparam int DIST_W     = 2 * COORD_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  issue,
  input  logic [IDX_W-1:0]      issue_idx,
  input  logic [PT_W-1:0]       rd_data,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  input  logic [COORD_BITS-1:0] q_z,
  output logic                  dist_valid,
  output logic [IDX_W-1:0]      dist_idx,
  output logic [DIST_W-1:0]     dist_sq,
  output logic                  busy
);

  localparam int SQ_W = 2 * COORD_BITS;

  logic v0, v1, v2, v3;
  logic [IDX_W-1:0] i0, i1, i2, i3;
  logic [COORD_BITS-1:0] p_x, p_y, p_z;
  logic [COORD_BITS:0] dx, dy, dz;
  logic [COORD_BITS-1:0] ax, ay, az;
  logic [SQ_W-1:0] sq_x, sq_y, sq_z;
  logic [DIST_W-1:0] sum;

  assign p_x = rd_data[PT_W-1 -: COORD_BITS];
  assign p_y = rd_data[2*COORD_BITS-1 -: COORD_BITS];
  assign p_z = rd_data[COORD_BITS-1:0];

  // The difference of two in-range coordinates never reaches the most
  // negative value, so the magnitude fits in COORD_BITS bits.
  always_comb begin
    ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    az = dz[COORD_BITS] ? COORD_BITS'(-dz) : COORD_BITS'(dz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    i0   <= issue_idx;
    i1   <= i0;
    i2   <= i1;
    i3   <= i2;
    dx   <= {p_x[COORD_BITS-1], p_x} - {q_x[COORD_BITS-1], q_x};
    dy   <= {p_y[COORD_BITS-1], p_y} - {q_y[COORD_BITS-1], q_y};
    dz   <= {p_z[COORD_BITS-1], p_z} - {q_z[COORD_BITS-1], q_z};
    sq_x <= SQ_W'(ax) * SQ_W'(ax);
    sq_y <= SQ_W'(ay) * SQ_W'(ay);
    sq_z <= SQ_W'(az) * SQ_W'(az);
    sum  <= DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
  end

  assign dist_valid = v3;
  assign dist_idx   = i3;
  assign dist_sq    = sum;
  assign busy       = v0 | v1 | v2 | v3;

endmodule

// File: src/bfk_sort.sv
// ----------------------------------------------------------------------------
// bfk_sort: sorted best list
// Keeps up to K_MAX nearest points in ascending distance. Each new distance
// is compared with all slots at once and inserted with a one-slot shift.
// ----------------------------------------------------------------------------
module bfk_sort #(
  parameter int  MAX_POINTS = bfk_pkg::MAX_POINTS_DEF,
  parameter int  K_MAX      = bfk_pkg::K_MAX_DEF,
  parameter int  COORD_BITS = bfk_pkg::COORD_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_POINTS),
  localparam int DIST_W     = 2 * COORD_BITS + 2,
  localparam int RANK_W     = (K_MAX > 1) ? $clog2(K_MAX) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  bfk_pkg::sort_ctl_t ctl,
  input  logic               ins_valid,
  input  logic [IDX_W-1:0]   ins_idx,
  input  logic [DIST_W-1:0]  ins_dist,
  input  logic [RANK_W-1:0]  sel,
  output logic [IDX_W-1:0]   sel_idx,
  output logic [DIST_W-1:0]  sel_dist,
  output logic               sel_last
);

  logic [K_MAX-1:0] b_vld;
  logic [IDX_W-1:0] b_idx [K_MAX];
  logic [DIST_W-1:0] b_dist [K_MAX];

  logic [K_MAX-1:0] gt;
  logic [K_MAX-1:0] upd;
  logic [K_MAX-1:0] nxt_vld;
  logic [K_MAX-1:0] last_v;
  logic [IDX_W-1:0] nxt_idx [K_MAX];
  logic [DIST_W-1:0] nxt_dist [K_MAX];

  // A slot is displaced when it is empty or holds a strictly larger distance,
  // so equal distances keep the earlier (lower) index ahead.
  for (genvar j = 0; j < K_MAX; j++) begin : g_slot
    assign gt[j]  = !b_vld[j] || (b_dist[j] > ins_dist);
    assign upd[j] = ins_valid && gt[j] && (j < int'(ctl.k_lim));
    if (j == 0) begin : g_head
      assign nxt_vld[j]  = 1'b1;
      assign nxt_idx[j]  = ins_idx;
      assign nxt_dist[j] = ins_dist;
    end else begin : g_body
      assign nxt_vld[j]  = gt[j-1] ? b_vld[j-1] : 1'b1;
      assign nxt_idx[j]  = gt[j-1] ? b_idx[j-1] : ins_idx;
      assign nxt_dist[j] = gt[j-1] ? b_dist[j-1] : ins_dist;
    end
    if (j == K_MAX - 1) begin : g_end
      assign last_v[j] = 1'b1;
    end else begin : g_mid
      assign last_v[j] = !b_vld[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= '0;
    end else if (ctl.clear) begin
      b_vld <= '0;
    end else begin
      for (int j = 0; j < K_MAX; j++) begin
        if (upd[j]) begin
          b_vld[j] <= nxt_vld[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < K_MAX; j++) begin
      if (upd[j]) begin
        b_idx[j]  <= nxt_idx[j];
        b_dist[j] <= nxt_dist[j];
      end
    end
  end

  assign sel_idx  = b_idx[sel];
  assign sel_dist = b_dist[sel];
  assign sel_last = last_v[sel];

  a_vld_prefix: assert property (@(posedge clk) disable iff (rst)
    ((b_vld + 1'b1) & b_vld) == '0)
    else $error("best list valid bits are not a contiguous prefix");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (b_vld == '0))
    else $error("best list not empty after clear");

  a_insert_fills_head: assert property (@(posedge clk) disable iff (rst)
    ins_valid && !ctl.clear |=> b_vld[0])
    else $error("nearest slot empty after an insertion");

endmodule

// File: src/brute_force_knn_search_top.sv
// ----------------------------------------------------------------------------
// brute_force_knn_search_top: brute-force k-nearest-neighbor search
// Stores 3-D target points and reports the k nearest of them for each query
// point by exact squared distance, ties going to the lower store index.
//
//   channel  signals                                        direction
//   in       in_valid/in_ready, op, coord_x/y/z, query_tag  to block
//   out      out_valid/out_ready, tag_out, found, rank,     from block
//            target_index, distance_sq, last
//   cfg      cfg_valid/cfg_ready, k_neighbors               to block
//
// Clear, append and unused ops leave the block idle and ready for the next item.
// A query reads one stored point per cycle through the memory read port into
// the pipelined distance unit, then gives its result beats in rank order, one
// per cycle while out_ready is high. An empty store gives one result beat, with
// found low. in_ready is low from query accept until the last beat is taken.
// Reset empties the store and sets k_neighbors to 1.
// ----------------------------------------------------------------------------
module brute_force_knn_search_top #(
  parameter int  MAX_POINTS = bfk_pkg::MAX_POINTS_DEF,
  parameter int  K_MAX      = bfk_pkg::K_MAX_DEF,
  parameter int  COORD_BITS = bfk_pkg::COORD_BITS_DEF,
  localparam int IDX_W      = $clog2(MAX_POINTS),
  localparam int DIST_W     = 2 * COORD_BITS + 2,
  localparam int RANK_W     = (K_MAX > 1) ? $clog2(K_MAX) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfk_pkg::OP_W-1:0]     op,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic [bfk_pkg::TAG_W-1:0]    query_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bfk_pkg::TAG_W-1:0]    tag_out,
  output logic                         found,
  output logic [RANK_W-1:0]            rank,
  output logic [IDX_W-1:0]             target_index,
  output logic [DIST_W-1:0]            distance_sq,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfk_pkg::CFG_W-1:0]    k_neighbors
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PT_W  = 3 * COORD_BITS;

  bfk_pkg::state_t state, state_next;
  bfk_pkg::sort_ctl_t sort_ctl;

  logic [CNT_W-1:0] point_count;
  logic [IDX_W-1:0] scan_idx;
  logic [COORD_BITS-1:0] q_x, q_y, q_z;
  logic [bfk_pkg::TAG_W-1:0] q_tag;
  logic [bfk_pkg::CFG_W-1:0] k_reg;
  logic [bfk_pkg::CFG_W-1:0] k_lim;
  logic empty_q;
  logic [RANK_W-1:0] rank_cnt;

  logic in_acc, out_acc, wr_en, rd_en, scan_done, query_go;
  logic dist_valid, dist_busy, sel_last;
  logic [IDX_W-1:0] dist_idx, sel_idx;
  logic [DIST_W-1:0] dist_sq, sel_dist;
  logic [PT_W-1:0] rd_data;

  assign in_ready  = (state == bfk_pkg::ST_IDLE);
  assign out_valid = (state == bfk_pkg::ST_EMIT);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  assign wr_en     = in_acc && (op == bfk_pkg::OP_APPEND)
                     && (point_count < CNT_W'(MAX_POINTS));
  assign query_go  = in_acc && (op == bfk_pkg::OP_QUERY);
  assign rd_en     = (state == bfk_pkg::ST_SCAN);
  assign scan_done = (CNT_W'(scan_idx) + 1'b1 == point_count);

  always_comb begin
    priority if (k_reg == '0) begin
      k_lim = bfk_pkg::CFG_W'(1);
    end else if (int'(k_reg) > K_MAX) begin
      k_lim = bfk_pkg::CFG_W'(K_MAX);
    end else begin
      k_lim = k_reg;
    end
  end

  assign sort_ctl.clear = query_go;
  assign sort_ctl.k_lim = k_lim;

  always_comb begin
    state_next = state;
    unique case (state)
      bfk_pkg::ST_IDLE: begin
        if (query_go) begin
          state_next = (point_count == '0) ? bfk_pkg::ST_EMIT : bfk_pkg::ST_SCAN;
        end
      end
      bfk_pkg::ST_SCAN: begin
        if (scan_done) state_next = bfk_pkg::ST_DRAIN;
      end
      bfk_pkg::ST_DRAIN: begin
        if (!dist_busy) state_next = bfk_pkg::ST_EMIT;
      end
      bfk_pkg::ST_EMIT: begin
        if (out_acc && last) state_next = bfk_pkg::ST_IDLE;
      end
      default: state_next = bfk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bfk_pkg::ST_IDLE;
      point_count <= '0;
      k_reg       <= bfk_pkg::K_RESET;
      empty_q     <= 1'b0;
      rank_cnt    <= '0;
      scan_idx    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        k_reg <= k_neighbors;
      end
      if (in_acc && (op == bfk_pkg::OP_CLEAR)) begin
        point_count <= '0;
      end
      if (wr_en) begin
        point_count <= point_count + 1'b1;
      end
      if (query_go) begin
        empty_q  <= (point_count == '0);
        rank_cnt <= '0;
        scan_idx <= '0;
      end
      if (rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (out_acc) begin
        rank_cnt <= rank_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      q_x   <= coord_x;
      q_y   <= coord_y;
      q_z   <= coord_z;
      q_tag <= query_tag;
    end
  end

  bfk_store #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(point_count[IDX_W-1:0]),
    .wr_data({coord_x, coord_y, coord_z}),
    .rd_en  (rd_en),
    .rd_addr(scan_idx),
    .rd_data(rd_data)
  );

  bfk_dist #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .issue     (rd_en),
    .issue_idx (scan_idx),
    .rd_data   (rd_data),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_z       (q_z),
    .dist_valid(dist_valid),
    .dist_idx  (dist_idx),
    .dist_sq   (dist_sq),
    .busy      (dist_busy)
  );

  bfk_sort #(
    .MAX_POINTS(MAX_POINTS),
    .K_MAX     (K_MAX),
    .COORD_BITS(COORD_BITS)
  ) u_sort (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sort_ctl),
    .ins_valid(dist_valid),
    .ins_idx  (dist_idx),
    .ins_dist (dist_sq),
    .sel      (rank_cnt),
    .sel_idx  (sel_idx),
    .sel_dist (sel_dist),
    .sel_last (sel_last)
  );

  assign tag_out      = q_tag;
  assign found        = !empty_q;
  assign rank         = rank_cnt;
  assign target_index = empty_q ? '0 : sel_idx;
  assign distance_sq  = empty_q ? '0 : sel_dist;
  assign last         = empty_q | sel_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_W'(MAX_POINTS))
    else $error("point count above store capacity");

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last && (rank == '0))
    else $error("empty-store result is not a single beat");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    out_acc && last |=> in_ready && !out_valid)
    else $error("block not idle after the last result beat");

  a_first_rank: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (rank == '0))
    else $error("first result beat of a query has nonzero rank");

endmodule

// File: sim/brute_force_knn_search_top_test.sv
// ----------------------------------------------------------------------------
// brute_force_knn_search_top_test: scoreboard test of the k-nearest search
// Drives clear, append, query and unused ops through the valid/ready input
// channel and checks every result beat against an in-bench model of the
// point store and the sorted neighbor list. A directed table covers the
// extremes and the corner cases, and random traffic runs under several idle
// and stall mixes with k_neighbors changed between phases.
// ----------------------------------------------------------------------------
module brute_force_knn_search_top_test;

  localparam int COORD_W = bfk_pkg::COORD_BITS_DEF;
  localparam int IDX_W   = $clog2(bfk_pkg::MAX_POINTS_DEF);
  localparam int DIST_W  = 2 * COORD_W + 2;
  localparam int RANK_W  = $clog2(bfk_pkg::K_MAX_DEF);
  localparam int LIMIT   = 200000;

  localparam logic [bfk_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t C_MIN  = 18'sh20000;
  localparam coord_t C_MAX  = 18'sh1FFFF;
  localparam coord_t C_ZERO = 18'sh00000;
  localparam coord_t C_NEG1 = 18'sh3FFFF;

  typedef struct packed {
    logic [bfk_pkg::TAG_W-1:0] tag;
    logic                      found;
    logic [RANK_W-1:0]         rank;
    logic [IDX_W-1:0]          index;
    logic [DIST_W-1:0]         dist_sq;
    logic                      last;
  } hit_t;

  typedef struct packed {
    logic                      set_k;
    logic [bfk_pkg::CFG_W-1:0] k_val;
    logic [bfk_pkg::OP_W-1:0]  op;
    coord_t                    x;
    coord_t                    y;
    coord_t                    z;
    logic [bfk_pkg::TAG_W-1:0] tag;
    logic                      typed;
    hit_t                      want;
  } script_row_t;

  localparam hit_t NO_HIT = '0;

  // Rows with typed set carry their single result beat; the rest go through
  // the model below.
  localparam script_row_t SCRIPT [18] = '{
    '{1'b0, 4'd0,  bfk_pkg::OP_QUERY,  C_ZERO, C_ZERO, C_ZERO, 16'hFFFF, 1'b1,
      '{16'hFFFF, 1'b0, 3'd0, 12'd0, 38'd0, 1'b1}},
    '{1'b0, 4'd0,  OP_UNUSED, C_MAX, C_MIN, C_MAX, 16'hAAAA, 1'b0, NO_HIT},
    '{1'b0, 4'd0,  bfk_pkg::OP_APPEND, C_MIN, C_MIN, C_MIN, 16'h0000, 1'b0, NO_HIT},
    '{1'b0, 4'd0,  bfk_pkg::OP_QUERY,  C_MAX, C_MAX, C_MAX, 16'h0000, 1'b1,
      '{16'h0000, 1'b1, 3'd0, 12'd0, 38'd206156857347, 1'b1}},
    '{1'b0, 4'd0,  bfk_pkg::OP_APPEND, C_MAX, C_MAX, C_MAX, 16'hFFFF, 1'b0, NO_HIT},
    '{1'b0, 4'd0,  bfk_pkg::OP_APPEND, C_ZERO, C_ZERO, C_ZERO, 16'h1111, 1'b0, NO_HIT},
    '{1'b0, 4'd0,  bfk_pkg::OP_APPEND, C_ZERO, C_ZERO, C_ZERO, 16'h2222, 1'b0, NO_HIT},
    '{1'b1, 4'd8,  bfk_pkg::OP_QUERY,  C_ZERO, C_ZERO, C_ZERO, 16'h1234, 1'b0, NO_HIT},
    '{1'b1, 4'd2,  bfk_pkg::OP_QUERY,  18'sh00001, C_ZERO, C_NEG1, 16'h00FF, 1'b0,
      NO_HIT},
    '{1'b1, 4'd0,  bfk_pkg::OP_QUERY,  C_NEG1, C_NEG1, C_NEG1, 16'hFF00, 1'b0, NO_HIT},
    '{1'b1, 4'd15, bfk_pkg::OP_QUERY,  C_MIN, C_MAX, C_ZERO, 16'h5555, 1'b0, NO_HIT},
    '{1'b1, 4'd9,  bfk_pkg::OP_QUERY,  18'sh00001, C_MIN, C_MAX, 16'hAAAA, 1'b0,
      NO_HIT},
    '{1'b0, 4'd0,  bfk_pkg::OP_CLEAR,  C_MAX, C_MAX, C_MAX, 16'hFFFF, 1'b0, NO_HIT},
    '{1'b0, 4'd0,  bfk_pkg::OP_QUERY,  C_MAX, C_MIN, C_NEG1, 16'h8000, 1'b1,
      '{16'h8000, 1'b0, 3'd0, 12'd0, 38'd0, 1'b1}},
    '{1'b0, 4'd0,  bfk_pkg::OP_APPEND, 18'sh15555, 18'sh0AAAA, 18'sh00001, 16'h0F0F,
      1'b0, NO_HIT},
    '{1'b0, 4'd0,  bfk_pkg::OP_APPEND, 18'sh0AAAA, 18'sh15555, C_NEG1, 16'hF0F0, 1'b0,
      NO_HIT},
    '{1'b1, 4'd1,  bfk_pkg::OP_QUERY,  18'sh15555, 18'sh15555, 18'sh15555, 16'h0001,
      1'b0, NO_HIT},
    '{1'b1, 4'd3,  bfk_pkg::OP_QUERY,  C_ZERO, C_ZERO, C_ZERO, 16'h7FFF, 1'b0, NO_HIT}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [bfk_pkg::OP_W-1:0]  op = bfk_pkg::OP_CLEAR;
  coord_t                    coord_x = '0;
  coord_t                    coord_y = '0;
  coord_t                    coord_z = '0;
  logic [bfk_pkg::TAG_W-1:0] query_tag = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [bfk_pkg::TAG_W-1:0] tag_out;
  logic                      found;
  logic [RANK_W-1:0]         rank;
  logic [IDX_W-1:0]          target_index;
  logic [DIST_W-1:0]         distance_sq;
  logic                      last;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [bfk_pkg::CFG_W-1:0] k_neighbors = bfk_pkg::K_RESET;

  // Model state: the point store, its fill level and the k setting.
  coord_t                    tgt_x [bfk_pkg::MAX_POINTS_DEF];
  coord_t                    tgt_y [bfk_pkg::MAX_POINTS_DEF];
  coord_t                    tgt_z [bfk_pkg::MAX_POINTS_DEF];
  int                        tgt_count = 0;
  logic [bfk_pkg::CFG_W-1:0] k_reg = bfk_pkg::K_RESET;

  hit_t                      hits_due [$];
  hit_t                      seen_hit;
  hit_t                      due_hit;
  int                        mismatch_count = 0;
  int                        cycle_count = 0;
  int                        idle_pct = 0;
  int                        stall_pct = 0;

  brute_force_knn_search_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .query_tag    (query_tag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tag_out      (tag_out),
    .found        (found),
    .rank         (rank),
    .target_index (target_index),
    .distance_sq  (distance_sq),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .k_neighbors  (k_neighbors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Applies one accepted item to the store and queues the beats of a query.
  function automatic void knn_predict_item(logic [bfk_pkg::OP_W-1:0] kind, coord_t px,
                                           coord_t py, coord_t pz,
                                           logic [bfk_pkg::TAG_W-1:0] ptag);
    int          k_eff;
    int          filled;
    int          pos;
    int          j;
    int          near_idx [bfk_pkg::K_MAX_DEF];
    logic [DIST_W-1:0] near_d [bfk_pkg::K_MAX_DEF];
    logic [DIST_W-1:0] d;
    longint      dx;
    longint      dy;
    longint      dz;
    hit_t        h;
    case (kind)
      bfk_pkg::OP_CLEAR: tgt_count = 0;
      bfk_pkg::OP_APPEND: begin
        if (tgt_count < bfk_pkg::MAX_POINTS_DEF) begin
          tgt_x[tgt_count] = px;
          tgt_y[tgt_count] = py;
          tgt_z[tgt_count] = pz;
          tgt_count++;
        end
      end
      bfk_pkg::OP_QUERY: begin
        if (tgt_count == 0) begin
          hits_due.push_back('{ptag, 1'b0, '0, '0, '0, 1'b1});
          return;
        end
        k_eff = (k_reg == 0) ? 1 : ((k_reg > bfk_pkg::K_MAX_DEF) ? bfk_pkg::K_MAX_DEF
                                                                 : int'(k_reg));
        filled = 0;
        for (int i = 0; i < tgt_count; i++) begin
          dx = longint'(tgt_x[i]) - longint'(px);
          dy = longint'(tgt_y[i]) - longint'(py);
          dz = longint'(tgt_z[i]) - longint'(pz);
          d = DIST_W'(dx * dx + dy * dy + dz * dz);
          // A new point only moves ahead of strictly farther entries, so
          // the lower store index wins a tie.
          pos = filled;
          while (pos > 0 && near_d[pos-1] > d) pos--;
          if (pos < k_eff) begin
            j = (filled < k_eff) ? filled : k_eff - 1;
            while (j > pos) begin
              near_idx[j] = near_idx[j-1];
              near_d[j] = near_d[j-1];
              j--;
            end
            near_idx[pos] = i;
            near_d[pos] = d;
            if (filled < k_eff) filled++;
          end
        end
        for (int r = 0; r < filled; r++) begin
          h.tag = ptag;
          h.found = 1'b1;
          h.rank = RANK_W'(r);
          h.index = IDX_W'(near_idx[r]);
          h.dist_sq = near_d[r];
          h.last = (r == filled - 1);
          hits_due.push_back(h);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return C_MIN;
          1: return C_MAX;
          2: return C_ZERO;
          default: return C_NEG1;
        endcase
      end
      // Tight clusters make equal distances common.
      2: return coord_t'($urandom_range(6)) - coord_t'(3);
      default: return coord_t'($urandom_range(2047)) - coord_t'(1024);
    endcase
  endfunction

  // Presents one input beat and waits for it to be taken. Valid is only
  // lowered when a gap is inserted, so back-to-back beats keep it high.
  task automatic send_item(input logic [bfk_pkg::OP_W-1:0] kind, input coord_t px,
                           input coord_t py, input coord_t pz,
                           input logic [bfk_pkg::TAG_W-1:0] ptag, input logic typed,
                           input hit_t typed_hit);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    op <= kind;
    coord_x <= px;
    coord_y <= py;
    coord_z <= pz;
    query_tag <= ptag;
    do @(posedge clk); while (!in_ready);
    if (typed) hits_due.push_back(typed_hit);
    else knn_predict_item(kind, px, py, pz, ptag);
  endtask

  // Waits until every queued beat has arrived and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_k(input logic [bfk_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    k_neighbors <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    k_reg = value;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_hit = {tag_out, found, rank, target_index, distance_sq, last};
      if (hits_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("cycle %0d: unexpected result beat: tag %h index %0d dist %0d",
                   cycle_count, seen_hit.tag, seen_hit.index, seen_hit.dist_sq);
      end else begin
        due_hit = hits_due.pop_front();
        if (seen_hit.tag !== due_hit.tag || seen_hit.found !== due_hit.found ||
            seen_hit.rank !== due_hit.rank || seen_hit.index !== due_hit.index ||
            seen_hit.dist_sq !== due_hit.dist_sq || seen_hit.last !== due_hit.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("cycle %0d: expected tag %h found %b rank %0d index %0d",
                     cycle_count, due_hit.tag, due_hit.found, due_hit.rank,
                     due_hit.index);
            $display("          expected dist %0d last %b",
                     due_hit.dist_sq, due_hit.last);
            $display("          actual tag %h found %b rank %0d index %0d",
                     seen_hit.tag, seen_hit.found, seen_hit.rank, seen_hit.index);
            $display("          actual dist %0d last %b",
                     seen_hit.dist_sq, seen_hit.last);
          end
        end
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    int                       counted;
    int                       pick;
    logic [bfk_pkg::OP_W-1:0] kind;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < $size(SCRIPT); n++) begin
      if (SCRIPT[n].set_k) begin
        settle();
        write_k(SCRIPT[n].k_val);
      end
      send_item(SCRIPT[n].op, SCRIPT[n].x, SCRIPT[n].y, SCRIPT[n].z, SCRIPT[n].tag,
                SCRIPT[n].typed, SCRIPT[n].want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      write_k(($urandom_range(3) == 0) ? bfk_pkg::CFG_W'($urandom_range(15))
                                       : bfk_pkg::CFG_W'($urandom_range(8, 1)));
      counted = 0;
      while (counted < 30) begin
        pick = $urandom_range(99);
        // Keep the store small so queries stay short.
        if (pick < 4 || (tgt_count > 20 && pick < 30)) kind = bfk_pkg::OP_CLEAR;
        else if (pick < 9) kind = OP_UNUSED;
        else if (pick < 55) kind = bfk_pkg::OP_APPEND;
        else kind = bfk_pkg::OP_QUERY;
        send_item(kind, rand_coord(), rand_coord(), rand_coord(), 16'($urandom),
                  1'b0, NO_HIT);
        if (kind != OP_UNUSED) counted++;
      end
    end

    settle();
    if (mismatch_count == 0 && hits_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
